FILE: hw/rtl/fifo_queue_with_search_delete_core_macros.svh
// assertion macros for the fifo queue with search and delete
// used by the top level only, expects clk and rst_n in scope
`ifndef FIFO_QUEUE_WITH_SEARCH_DELETE_CORE_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_DELETE_CORE_MACROS_SVH

// same-cycle implication
`define FQSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqsd check failed");

// next-cycle implication
`define FQSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqsd check failed");

`endif

FILE: hw/rtl/fqsd_pkg.sv
// shared types and codes for the fifo queue with search and delete
// no dependencies
package fqsd_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;

    typedef logic [1:0]               kind_t;
    typedef logic [1:0]               status_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         count_t;

    localparam kind_t KIND_ENQ  = 2'd0;
    localparam kind_t KIND_DEQ  = 2'd1;
    localparam kind_t KIND_DEL  = 2'd2;
    localparam kind_t KIND_SCAN = 2'd3;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

endpackage

FILE: hw/rtl/fifo_queue_with_search_delete_core.sv
// flow: enqueue writes the ram at accept unless full, dequeue pops the front, delete
// and scan walk the entries from the front; then front and rear are re-read from the
// ram, except when the queue ends up empty; the core takes one item at a time:
// in_stall is high from accept until the result is registered
// reset: async active low, clears head, occupancy and control; ram contents stay
// undefined, no clearing pass
`include "fifo_queue_with_search_delete_core_macros.svh"

module fifo_queue_with_search_delete_core
    import fqsd_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  kind_t   kind,
    input  word_t   value,
    output logic    out_valid,
    input  logic    out_stall,
    output status_t status,
    output word_t   data_out,
    output count_t  occurrences,
    output word_t   max_value,
    output word_t   min_value,
    output word_t   front_value,
    output word_t   rear_value,
    output count_t  item_count,
    output logic    is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_FRONT  = 3'd4;
    localparam logic [2:0] S_REAR   = 3'd5;
    localparam logic [2:0] S_REAR_W = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // physical slot of base + off, wrapped once
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(CAPACITY))
        begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    // control
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0] cmp_ptr_reg, cmp_ptr_next;
    logic [CW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0] dst_ptr_reg, dst_ptr_next;
    logic          out_valid_reg, out_valid_next;

    // working payload
    kind_t         kind_reg, kind_next;
    word_t         val_reg, val_next;
    status_t       st_reg, st_next;
    word_t         data_reg, data_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    word_t         max_reg, max_next;
    word_t         min_reg, min_next;
    word_t         front_reg, front_next;
    word_t         rear_reg, rear_next;

    // result beat
    status_t out_status_reg, out_status_next;
    word_t   out_data_reg, out_data_next;
    count_t  out_occ_reg, out_occ_next;
    word_t   out_max_reg, out_max_next;
    word_t   out_min_reg, out_min_next;
    word_t   out_front_reg, out_front_next;
    word_t   out_rear_reg, out_rear_next;
    count_t  out_count_reg, out_count_next;
    logic    out_empty_reg, out_empty_next;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    word_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata_raw;
    word_t         ram_rdata;

    logic          accept;
    logic          issue;
    logic          cmp_last;
    logic [CW-1:0] occ_last;
    logic          queue_full;
    logic          out_ends_zero;

    fqsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_raw)
    );

    assign ram_rdata = $signed(ram_rdata_raw);
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign occ_last  = occ_reg - CW'(1);
    assign issue     = (rd_idx_reg < occ_reg);
    assign cmp_last  = (cmp_idx_reg == occ_last);
    assign queue_full    = (occ_reg == CW'(CAPACITY));
    assign out_ends_zero = (out_front_reg == '0) && (out_rear_reg == '0)
                           && (out_count_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        occ_next      = occ_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_ptr_next  = cmp_ptr_reg;
        cmp_idx_next  = cmp_idx_reg;
        dst_ptr_next  = dst_ptr_reg;
        out_valid_next = out_valid_reg && out_stall;

        kind_next  = kind_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        front_next = front_reg;
        rear_next  = rear_reg;

        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_occ_next    = out_occ_reg;
        out_max_next    = out_max_reg;
        out_min_next    = out_min_reg;
        out_front_next  = out_front_reg;
        out_rear_next   = out_rear_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_add(head_reg, occ_reg);
        ram_wdata = value;
        ram_raddr = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = kind;
                    val_next    = value;
                    st_next     = ST_OK;
                    data_next   = '0;
                    cnt_next    = '0;
                    max_next    = '0;
                    min_next    = '0;
                    rd_ptr_next = head_reg;
                    rd_idx_next = '0;
                    case (kind)
                        KIND_ENQ:
                        begin
                            if (occ_reg == CW'(CAPACITY))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                occ_next = occ_reg + CW'(1);
                            end
                            state_next = S_FRONT;
                        end
                        KIND_DEQ:
                        begin
                            if (occ_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FRONT;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            if (occ_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FRONT;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                    endcase
                end
            end

            S_WALK, S_SHIFT:
            begin
                // stream reads one slot per cycle, data lands in the next cycle
                ram_raddr = rd_ptr_reg;
                if (issue)
                begin
                    rd_ptr_next  = ptr_inc(rd_ptr_reg);
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_ptr_next = rd_ptr_reg;
                    cmp_idx_next = rd_idx_reg;
                end
                if (cmp_vld_reg)
                begin
                    if (state_reg == S_SHIFT)
                    begin
                        // close the gap: move entry one slot toward the front
                        ram_we       = 1'b1;
                        ram_waddr    = dst_ptr_reg;
                        ram_wdata    = ram_rdata;
                        dst_ptr_next = cmp_ptr_reg;
                        if (cmp_last)
                        begin
                            occ_next   = occ_last;
                            state_next = S_FRONT;
                        end
                    end
                    else if (kind_reg == KIND_SCAN)
                    begin
                        if (ram_rdata == val_reg)
                        begin
                            cnt_next = cnt_reg + CW'(1);
                        end
                        if (cmp_idx_reg == '0)
                        begin
                            max_next = ram_rdata;
                            min_next = ram_rdata;
                        end
                        else
                        begin
                            if (ram_rdata > max_reg)
                            begin
                                max_next = ram_rdata;
                            end
                            if (ram_rdata < min_reg)
                            begin
                                min_next = ram_rdata;
                            end
                        end
                        if (cmp_last)
                        begin
                            state_next = S_FRONT;
                        end
                    end
                    else
                    begin
                        if (ram_rdata == val_reg)
                        begin
                            data_next    = ram_rdata;
                            dst_ptr_next = cmp_ptr_reg;
                            if (cmp_last)
                            begin
                                occ_next   = occ_last;
                                state_next = S_FRONT;
                            end
                            else
                            begin
                                state_next = S_SHIFT;
                            end
                        end
                        else if (cmp_last)
                        begin
                            st_next    = ST_NOTFOUND;
                            state_next = S_FRONT;
                        end
                    end
                end
            end

            S_POP:
            begin
                data_next  = ram_rdata;
                head_next  = ptr_inc(head_reg);
                occ_next   = occ_last;
                state_next = S_FRONT;
            end

            S_FRONT:
            begin
                ram_raddr = head_reg;
                if (occ_reg == '0)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_REAR;
                end
            end

            S_REAR:
            begin
                front_next = ram_rdata;
                ram_raddr  = slot_add(head_reg, occ_last);
                state_next = S_REAR_W;
            end

            S_REAR_W:
            begin
                rear_next  = ram_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_data_next   = data_reg;
                    out_occ_next    = CNT_W'(cnt_reg);
                    out_max_next    = max_reg;
                    out_min_next    = min_reg;
                    out_front_next  = front_reg;
                    out_rear_next   = rear_reg;
                    out_count_next  = CNT_W'(occ_reg);
                    out_empty_next  = (occ_reg == '0);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            rd_ptr_reg    <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_ptr_reg   <= '0;
            cmp_idx_reg   <= '0;
            dst_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_ENQ;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_ptr_reg   <= cmp_ptr_next;
            cmp_idx_reg   <= cmp_idx_next;
            dst_ptr_reg   <= dst_ptr_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        st_reg         <= st_next;
        data_reg       <= data_next;
        cnt_reg        <= cnt_next;
        max_reg        <= max_next;
        min_reg        <= min_next;
        front_reg      <= front_next;
        rear_reg       <= rear_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_occ_reg    <= out_occ_next;
        out_max_reg    <= out_max_next;
        out_min_reg    <= out_min_next;
        out_front_reg  <= out_front_next;
        out_rear_reg   <= out_rear_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign data_out    = out_data_reg;
    assign occurrences = out_occ_reg;
    assign max_value   = out_max_reg;
    assign min_value   = out_min_reg;
    assign front_value = out_front_reg;
    assign rear_value  = out_rear_reg;
    assign item_count  = out_count_reg;
    assign is_empty    = out_empty_reg;

    `FQSD_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= CW'(CAPACITY))
    `FQSD_ASSERT_NEXT(a_busy_after_accept, accept, state_reg != S_IDLE)
    `FQSD_ASSERT_NOW(a_empty_zero_ends, out_valid_reg && out_empty_reg, out_ends_zero)
    `FQSD_ASSERT_NEXT(a_full_holds, accept && (kind == KIND_ENQ) && queue_full, queue_full)

endmodule

FILE: hw/rtl/fqsd_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module fqsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// testbench for fifo_queue_with_search_delete_core: directed and random queue ops,
// results checked beat by beat against a queue predictor held in the bench
// depends on fqsd_pkg and the core rtl
module tb;
    import fqsd_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PER_PHASE = 275;

    typedef struct packed {
        kind_t kind;
        word_t value;
    } queue_op_t;

    typedef struct packed {
        status_t status;
        word_t   data_out;
        count_t  occurrences;
        word_t   max_value;
        word_t   min_value;
        word_t   front_value;
        word_t   rear_value;
        count_t  item_count;
        logic    is_empty;
    } queue_result_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    kind_t   kind;
    word_t   value;
    logic    out_valid;
    logic    out_stall;
    status_t status;
    word_t   data_out;
    count_t  occurrences;
    word_t   max_value;
    word_t   min_value;
    word_t   front_value;
    word_t   rear_value;
    count_t  item_count;
    logic    is_empty;

    queue_op_t     pending_ops[$];
    queue_result_t predicted_results[$];
    word_t         model_words[$];
    word_t         value_pool[8];
    queue_op_t     next_op;
    queue_result_t oldest_result;
    logic          op_taken;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            mismatch_count;
    int            quiet_cycles;

    fifo_queue_with_search_delete_core #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .data_out   (data_out),
        .occurrences(occurrences),
        .max_value  (max_value),
        .min_value  (min_value),
        .front_value(front_value),
        .rear_value (rear_value),
        .item_count (item_count),
        .is_empty   (is_empty)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // applies one op to the bench copy of the queue and returns the expected beat
    function automatic queue_result_t apply_queue_op(input kind_t op_kind, input word_t op_value);
        queue_result_t r;
        int            hit;
        r = '0;
        r.status = ST_OK;
        case (op_kind)
            KIND_ENQ:
            begin
                if (model_words.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                    model_words.push_back(op_value);
            end
            KIND_DEQ:
            begin
                if (model_words.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.data_out = model_words.pop_front();
            end
            KIND_DEL:
            begin
                if (model_words.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    hit = -1;
                    for (int i = 0; i < model_words.size(); i++)
                    begin
                        if (hit < 0 && model_words[i] == op_value)
                            hit = i;
                    end
                    if (hit < 0)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        r.data_out = model_words[hit];
                        model_words.delete(hit);
                    end
                end
            end
            default:
            begin
                if (model_words.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.max_value = model_words[0];
                    r.min_value = model_words[0];
                    for (int i = 0; i < model_words.size(); i++)
                    begin
                        if (model_words[i] == op_value)
                            r.occurrences = r.occurrences + 1'b1;
                        if (model_words[i] > r.max_value)
                            r.max_value = model_words[i];
                        if (model_words[i] < r.min_value)
                            r.min_value = model_words[i];
                    end
                end
            end
        endcase
        if (model_words.size() != 0)
        begin
            r.front_value = model_words[0];
            r.rear_value  = model_words[model_words.size() - 1];
        end
        r.item_count = count_t'(model_words.size());
        r.is_empty   = (model_words.size() == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %h actual %h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    task automatic push_op(input kind_t op_kind, input word_t op_value);
        queue_op_t op;
        op.kind  = op_kind;
        op.value = op_value;
        pending_ops.push_back(op);
    endtask

    // bursts that mostly fill or mostly drain, values mostly drawn from a small pool
    // so that deletes hit and scans count duplicates
    task automatic add_random_ops(input int n);
        bit    filling;
        int    pick;
        kind_t k;
        word_t v;
        filling = 1'b1;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++)
            value_pool[i] = word_t'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (i % 30 == 29)
                filling = ~filling;
            pick = $urandom_range(99);
            if (pick < (filling ? 65 : 20))
                k = KIND_ENQ;
            else if (pick < (filling ? 75 : 55))
                k = KIND_DEQ;
            else if (pick < (filling ? 88 : 80))
                k = KIND_DEL;
            else
                k = KIND_SCAN;
            if ($urandom_range(99) < 65)
                v = value_pool[$urandom_range(7)];
            else
                v = word_t'($urandom);
            push_op(k, v);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        add_random_ops(RANDOM_PER_PHASE);
        while (pending_ops.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        word_t last_word;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_ENQ;
        value          = '0;
        out_stall      = 1'b0;
        op_taken       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        last_word      = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ops on an empty queue
        push_op(KIND_DEQ, '0);
        push_op(KIND_DEL, '0);
        push_op(KIND_SCAN, '0);
        // fill to capacity with the extremes and a duplicate
        push_op(KIND_ENQ, 32'sh8000_0000);
        push_op(KIND_ENQ, 32'sh7fff_ffff);
        push_op(KIND_ENQ, '0);
        push_op(KIND_ENQ, -32'sd1);
        push_op(KIND_ENQ, 32'sd1);
        push_op(KIND_ENQ, 32'sh7fff_ffff);
        for (int i = 0; i < CAPACITY - 6; i++)
        begin
            last_word = word_t'($urandom);
            push_op(KIND_ENQ, last_word);
        end
        push_op(KIND_ENQ, 32'sd123);
        push_op(KIND_SCAN, 32'sh7fff_ffff);
        push_op(KIND_DEL, 32'sh1234_5677);
        // delete in the middle, at the rear and at the front
        push_op(KIND_DEL, '0);
        push_op(KIND_DEL, last_word);
        push_op(KIND_DEL, 32'sh8000_0000);
        push_op(KIND_DEQ, '0);
        while (pending_ops.size() != 0)
            @(posedge clk);

        run_phase(0, 0);
        run_phase(86, 0);
        run_phase(0, 86);
        run_phase(9, 9);

        while (in_valid || predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // driver: a new beat only once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || op_taken)
            begin
                op_taken = 1'b0;
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_op = pending_ops.pop_front();
                    kind     <= next_op.kind;
                    value    <= next_op.value;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: predict on input beats, compare on output beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted_results.push_back(apply_queue_op(kind, value));
                op_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    mismatch_count++;
                end
                else
                begin
                    oldest_result = predicted_results.pop_front();
                    check_field("status", 32'(oldest_result.status), 32'(status));
                    check_field("data_out", oldest_result.data_out, data_out);
                    check_field("occurrences", 32'(oldest_result.occurrences),
                                32'(occurrences));
                    check_field("max_value", oldest_result.max_value, max_value);
                    check_field("min_value", oldest_result.min_value, min_value);
                    check_field("front_value", oldest_result.front_value, front_value);
                    check_field("rear_value", oldest_result.rear_value, rear_value);
                    check_field("item_count", 32'(oldest_result.item_count),
                                32'(item_count));
                    check_field("is_empty", 32'(oldest_result.is_empty), 32'(is_empty));
                end
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
